FILE: src/bfx_pkg.sv
// Shared types and constants of the xorshift-chain Bloom filter.
package bfx_pkg;

    localparam int FILTER_BITS_DEF = 65536;
    localparam int MAX_HASHES_DEF  = 64;

    localparam int KEY_W      = 64;
    localparam int SIZE_W     = 17;
    localparam int HC_W       = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SIZE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT  = 8'd1;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // bit array is stored as rows of ROW_W bits
    localparam int ROW_W     = 64;
    localparam int ROW_SEL_W = $clog2(ROW_W);

    // front/back queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // remainder unit: MOD_DIGIT_W dividend bits per cycle
    localparam int MOD_DIGIT_W = 8;
    localparam int MOD_STEPS   = KEY_W / MOD_DIGIT_W;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

    // one bit access handed from front to back
    typedef struct packed {
        logic              func;
        logic              last;
        logic              has_pos;
        logic [SIZE_W-1:0] pos;
    } t_entry;

endpackage

FILE: src/bloom_filter_xorshift_chain.sv
// Top level of the xorshift-chain Bloom filter.
//
// One item at a time: an item is taken when start is high and busy is low,
// and busy stays high until its work is done. Each hash takes one xorshift
// step, then the remainder unit (8 key bits per cycle against the configured
// size), then a push of the bit address into the queue, held while the queue
// is full. After the last address is queued, the back end pops it and reads
// its row, then checks the bit or writes it back. The back end keeps up with
// the front throughout.
// A query gives its answer on o_present with a one-cycle o_strobe in the
// first cycle with busy low, which is also the last cycle of the item; the
// receiver must take it in that cycle. An insert gives nothing. With a
// hash count of zero a query answers 1. After reset the bit array is
// cleared one 64-bit row per cycle, with busy high; config writes are taken
// at any time but should only be issued while busy is low.
module bloom_filter_xorshift_chain #(
    parameter int FILTER_BITS = bfx_pkg::FILTER_BITS_DEF,
    parameter int MAX_HASHES  = bfx_pkg::MAX_HASHES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write port
    input  logic                           i_cfg_we,
    input  logic [bfx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bfx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // item command
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_func,
    input  logic [bfx_pkg::KEY_W-1:0]      i_key,
    // result
    output logic                           o_strobe,
    output logic                           o_present
);

    logic            accept;
    logic            front_busy, back_busy;
    logic            q_push, q_pop, q_full, q_empty;
    bfx_pkg::t_entry q_in, q_out;

    // busy covers the clearing pass, hashing, queued accesses and the back end
    assign busy   = front_busy | back_busy | ~q_empty;
    assign accept = start & ~busy;

    bfx_front #(
        .FILTER_BITS(FILTER_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_func     (i_func),
        .i_key      (i_key),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_entry  (q_in),
        .o_busy     (front_busy)
    );

    bfx_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_empty (q_empty)
    );

    bfx_back #(
        .FILTER_BITS(FILTER_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_entry (q_out),
        .o_q_pop   (q_pop),
        .o_strobe  (o_strobe),
        .o_present (o_present),
        .o_busy    (back_busy)
    );

endmodule

FILE: src/bfx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/bfx_front.sv
// Front end: config registers, item capture, xorshift chain and remainder unit.
module bfx_front #(
    parameter int FILTER_BITS = bfx_pkg::FILTER_BITS_DEF,
    parameter int MAX_HASHES  = bfx_pkg::MAX_HASHES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bfx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bfx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_accept,
    input  logic                           i_func,
    input  logic [bfx_pkg::KEY_W-1:0]      i_key,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output bfx_pkg::t_entry                o_q_entry,
    output logic                           o_busy
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HASH = 4'b0010,
        S_MOD  = 4'b0100,
        S_PUSH = 4'b1000
    } t_state;

    function automatic logic [63:0] xs64(input logic [63:0] v);
        logic [63:0] a;
        a = v ^ (v << 13);
        a = a ^ (a >> 7);
        a = a ^ (a << 17);
        return a;
    endfunction

    // restoring remainder, one dividend digit (MSB first)
    function automatic logic [bfx_pkg::SIZE_W-1:0] mod_digit(
        input logic [bfx_pkg::SIZE_W-1:0]      rem,
        input logic [bfx_pkg::MOD_DIGIT_W-1:0] dig,
        input logic [bfx_pkg::SIZE_W-1:0]      size
    );
        logic [bfx_pkg::SIZE_W:0]   t;
        logic [bfx_pkg::SIZE_W-1:0] r;
        r = rem;
        for (int b = bfx_pkg::MOD_DIGIT_W - 1; b >= 0; b--) begin
            t = {r, dig[b]};
            if (t >= {1'b0, size}) begin
                t = t - {1'b0, size};
            end
            r = t[bfx_pkg::SIZE_W-1:0];
        end
        return r;
    endfunction

    t_state                          r_state, n_state;
    logic [bfx_pkg::SIZE_W-1:0]      r_fsize;
    logic [bfx_pkg::HC_W-1:0]        r_hcount;
    logic [bfx_pkg::MOD_CNT_W-1:0]   r_dig, n_dig;
    logic [bfx_pkg::HC_W-1:0]        r_left, n_left;

    logic                            r_func, n_func;
    logic                            r_has, n_has;
    logic [bfx_pkg::KEY_W-1:0]       r_h, n_h;
    logic [bfx_pkg::KEY_W-1:0]       r_div, n_div;
    logic [bfx_pkg::SIZE_W-1:0]      r_size, n_size;
    logic [bfx_pkg::SIZE_W-1:0]      r_rem, n_rem;

    logic [bfx_pkg::SIZE_W-1:0]      eff_size;
    logic [bfx_pkg::HC_W-1:0]        eff_count;
    logic [bfx_pkg::KEY_W-1:0]       h_next;
    logic                            last_hash;

    // zero size acts as one, oversize saturates to the array size; the hash count saturates to MAX_HASHES
    always_comb begin
        if (r_fsize == '0) begin
            eff_size = bfx_pkg::SIZE_W'(1);
        end else if (32'(r_fsize) > 32'(FILTER_BITS)) begin
            eff_size = bfx_pkg::SIZE_W'(FILTER_BITS);
        end else begin
            eff_size = r_fsize;
        end
        if (32'(r_hcount) > 32'(MAX_HASHES)) begin
            eff_count = bfx_pkg::HC_W'(MAX_HASHES);
        end else begin
            eff_count = r_hcount;
        end
    end

    assign h_next    = xs64(r_h);
    assign last_hash = (r_left <= bfx_pkg::HC_W'(1));

    always_comb begin
        n_state = r_state;
        n_dig   = r_dig;
        n_left  = r_left;
        n_func  = r_func;
        n_has   = r_has;
        n_h     = r_h;
        n_div   = r_div;
        n_size  = r_size;
        n_rem   = r_rem;
        o_q_push = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_func = i_func;
                    n_h    = i_key;
                    n_size = eff_size;
                    n_left = eff_count;
                    n_has  = (eff_count != '0);
                    n_rem  = '0;
                    n_state = (eff_count == '0) ? S_PUSH : S_HASH;
                end
            end
            S_HASH: begin
                n_h     = h_next;
                n_div   = h_next;
                n_rem   = '0;
                n_dig   = '0;
                n_state = S_MOD;
            end
            S_MOD: begin
                n_rem = mod_digit(r_rem,
                                  r_div[bfx_pkg::KEY_W-1 -: bfx_pkg::MOD_DIGIT_W],
                                  r_size);
                n_div = r_div << bfx_pkg::MOD_DIGIT_W;
                n_dig = r_dig + bfx_pkg::MOD_CNT_W'(1);
                if (r_dig == bfx_pkg::MOD_CNT_W'(bfx_pkg::MOD_STEPS - 1)) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    if (last_hash) begin
                        n_state = S_IDLE;
                    end else begin
                        n_left  = r_left - bfx_pkg::HC_W'(1);
                        n_state = S_HASH;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fsize  <= bfx_pkg::SIZE_W'(65536);
            r_hcount <= bfx_pkg::HC_W'(4);
            r_dig    <= '0;
            r_left   <= '0;
        end else begin
            r_state <= n_state;
            r_dig   <= n_dig;
            r_left  <= n_left;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bfx_pkg::CFG_FILTER_SIZE: begin
                        r_fsize <= i_cfg_data[bfx_pkg::SIZE_W-1:0];
                    end
                    bfx_pkg::CFG_HASH_COUNT: begin
                        r_hcount <= i_cfg_data[bfx_pkg::HC_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_has  <= n_has;
        r_h    <= n_h;
        r_div  <= n_div;
        r_size <= n_size;
        r_rem  <= n_rem;
    end

    assign o_q_entry.func    = r_func;
    assign o_q_entry.last    = last_hash;
    assign o_q_entry.has_pos = r_has;
    assign o_q_entry.pos     = r_rem;
    assign o_busy            = (r_state != S_IDLE);

endmodule

FILE: src/bfx_fifo.sv
// Short queue of bit accesses between front and back.
module bfx_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bfx_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output bfx_pkg::t_entry o_entry,
    output logic            o_empty
);

    bfx_pkg::t_entry               r_buf [bfx_pkg::Q_DEPTH];
    logic [bfx_pkg::Q_PTR_W-1:0]   r_wptr, r_rptr;
    logic [bfx_pkg::Q_PTR_W:0]     r_cnt;
    logic                          do_push, do_pop;

    assign o_full  = (r_cnt == (bfx_pkg::Q_PTR_W + 1)'(bfx_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_buf[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + bfx_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + bfx_pkg::Q_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (bfx_pkg::Q_PTR_W + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (bfx_pkg::Q_PTR_W + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wptr] <= i_entry;
        end
    end

endmodule

FILE: src/bfx_back.sv
// Back end: bit array clearing pass, read-modify-write of bits, query answer.
module bfx_back #(
    parameter int FILTER_BITS = bfx_pkg::FILTER_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  bfx_pkg::t_entry i_q_entry,
    output logic            o_q_pop,
    output logic            o_strobe,
    output logic            o_present,
    output logic            o_busy
);

    localparam int ROWS   = (FILTER_BITS + bfx_pkg::ROW_W - 1) / bfx_pkg::ROW_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BIT_AW = $clog2(FILTER_BITS);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_CHK   = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [ROW_AW-1:0]               r_clr_row, n_clr_row;
    logic                            r_all_set, n_all_set;
    logic                            r_strobe, n_strobe;
    logic                            r_present, n_present;
    bfx_pkg::t_entry                 r_ent, n_ent;

    logic [BIT_AW-1:0]               in_bit, cur_bit;
    logic [ROW_AW-1:0]               cur_row;
    logic [bfx_pkg::ROW_SEL_W-1:0]   cur_sel;
    logic                            ram_we;
    logic [ROW_AW-1:0]               ram_waddr, ram_raddr;
    logic [bfx_pkg::ROW_W-1:0]       ram_wdata, ram_q;
    logic                            bit_val;

    assign in_bit  = BIT_AW'(i_q_entry.pos);
    assign cur_bit = BIT_AW'(r_ent.pos);
    assign cur_row = ROW_AW'(cur_bit >> bfx_pkg::ROW_SEL_W);
    assign cur_sel = cur_bit[bfx_pkg::ROW_SEL_W-1:0];
    assign bit_val = ram_q[cur_sel];

    bfx_ram #(
        .WIDTH(bfx_pkg::ROW_W),
        .DEPTH(ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state   = r_state;
        n_clr_row = r_clr_row;
        n_all_set = r_all_set;
        n_strobe  = 1'b0;
        n_present = r_present;
        n_ent     = r_ent;
        o_q_pop   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = cur_row;
        ram_wdata = ram_q | (bfx_pkg::ROW_W'(1) << cur_sel);
        ram_raddr = ROW_AW'(in_bit >> bfx_pkg::ROW_SEL_W);
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_row;
                ram_wdata = '0;
                n_clr_row = r_clr_row + ROW_AW'(1);
                if (r_clr_row == ROW_AW'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_ent   = i_q_entry;
                    if (i_q_entry.has_pos) begin
                        n_state = S_CHK;
                    end else begin
                        // zero hash count: nothing to touch, query answers set
                        n_strobe  = (i_q_entry.func == bfx_pkg::FUNC_QUERY);
                        n_present = r_all_set;
                        n_all_set = 1'b1;
                    end
                end
            end
            S_CHK: begin
                if (r_ent.func == bfx_pkg::FUNC_INSERT) begin
                    ram_we = 1'b1;
                end
                if (r_ent.last) begin
                    n_strobe  = (r_ent.func == bfx_pkg::FUNC_QUERY);
                    n_present = r_all_set & (bit_val | (r_ent.func == bfx_pkg::FUNC_INSERT));
                    n_all_set = 1'b1;
                end else if (r_ent.func == bfx_pkg::FUNC_QUERY) begin
                    n_all_set = r_all_set & bit_val;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_row <= '0;
            r_all_set <= 1'b1;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_row <= n_clr_row;
            r_all_set <= n_all_set;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_present <= n_present;
        r_ent     <= n_ent;
    end

    assign o_strobe  = r_strobe;
    assign o_present = r_present;
    assign o_busy    = (r_state != S_IDLE);

endmodule

FILE: bench/bloom_filter_xorshift_chain_checker.sv
`timescale 1ns / 100ps
// Filter checker: tracks the bit array, predicts query answers and compares them.
module bloom_filter_xorshift_chain_checker
    import bfx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic                  i_func,
    input  logic [KEY_W-1:0]      i_key,
    input  logic                  i_strobe,
    input  logic                  i_present,
    output int                    o_errors,
    output int                    o_waiting
);

    logic              member_bits [FILTER_BITS_DEF];
    logic [SIZE_W-1:0] cfg_size;
    logic [HC_W-1:0]   hash_count;
    logic              answers_due [$];
    int                fault_count = 0;

    assign o_errors = fault_count;

    function automatic logic [KEY_W-1:0] xorshift_step(input logic [KEY_W-1:0] v);
        v = v ^ (v << 13);
        v = v ^ (v >> 7);
        v = v ^ (v << 17);
        return v;
    endfunction

    // walk the hash chain; inserts set bits, queries queue their answer
    task automatic apply_key(input logic func, input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] h;
        logic [KEY_W-1:0] span;
        int               rounds;
        int unsigned      pos;
        logic             all_set;
        span    = (cfg_size == '0) ? KEY_W'(1) :
                  (32'(cfg_size) > FILTER_BITS_DEF) ? KEY_W'(FILTER_BITS_DEF) :
                  KEY_W'(cfg_size);
        rounds  = (32'(hash_count) > MAX_HASHES_DEF) ? MAX_HASHES_DEF : 32'(hash_count);
        h       = key;
        all_set = 1'b1;
        for (int n = 0; n < rounds; n++) begin
            h   = xorshift_step(h);
            pos = 32'(h % span);
            if (func == FUNC_INSERT) begin
                member_bits[pos] = 1'b1;
            end else if (!member_bits[pos]) begin
                all_set = 1'b0;
            end
        end
        if (func == FUNC_QUERY) begin
            answers_due.push_back(all_set);
        end
    endtask

    task automatic note_fault(input string what, input logic exp, input logic act);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t: %s: expected present %b, got %b", $time, what, exp, act);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (member_bits[n]) member_bits[n] = 1'b0;
            cfg_size   = SIZE_W'(FILTER_BITS_DEF);
            hash_count = HC_W'(4);
            answers_due.delete();
        end else begin
            // results first: one that leaves now belongs to an earlier item
            if (i_strobe) begin
                if (answers_due.size() == 0) begin
                    note_fault("result with nothing pending", 1'bx, i_present);
                end else if (answers_due.pop_front() !== i_present) begin
                    note_fault("query answer mismatch", ~i_present, i_present);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FILTER_SIZE: cfg_size   = i_cfg_data[SIZE_W-1:0];
                    CFG_HASH_COUNT:  hash_count = i_cfg_data[HC_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                apply_key(i_func, i_key);
            end
        end
        o_waiting = answers_due.size();
    end

endmodule

FILE: bench/bloom_filter_xorshift_chain_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives keys and settings into the Bloom filter and gives the verdict.
module bloom_filter_xorshift_chain_tb;
    import bfx_pkg::*;

    // slowest item: 64 hashes plus overhead
    localparam int ITEM_CYCLES = 10 * MAX_HASHES_DEF + 4;
    localparam int SETTLE      = ITEM_CYCLES + 16;
    // longest quiet stretch is the clearing pass or one settle pause; allow far more
    localparam int STALL_LIMIT = 10000;

    // register indexes the block does not decode; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX   = 8'hFF;

    localparam logic [KEY_W-1:0] KEY_ZERO = '0;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;
    localparam logic [KEY_W-1:0] KEY_MSB  = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic [KEY_W-1:0] KEY_LSB  = KEY_W'(1);

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  start      = 1'b0;
    logic                  busy;
    logic                  i_func     = FUNC_INSERT;
    logic [KEY_W-1:0]      i_key      = '0;
    logic                  o_strobe;
    logic                  o_present;

    int               fault_count;
    int               answers_pending;
    int               stall_cycles = 0;
    logic             no_gaps      = 1'b0;
    logic [KEY_W-1:0] inserted_keys [$];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    bloom_filter_xorshift_chain i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .start      (start),
        .busy       (busy),
        .i_func     (i_func),
        .i_key      (i_key),
        .o_strobe   (o_strobe),
        .o_present  (o_present)
    );

    bloom_filter_xorshift_chain_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_start    (start),
        .i_busy     (busy),
        .i_func     (i_func),
        .i_key      (i_key),
        .i_strobe   (o_strobe),
        .i_present  (o_present),
        .o_errors   (fault_count),
        .o_waiting  (answers_pending)
    );

    // watchdog: any accepted item, result or register write restarts the count
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("bloom_filter_xorshift_chain_tb: done, errors");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // Present one item and hold it until the block takes it. Busy is read right
    // after the edge, so it is the value the block saw at that edge. Start stays
    // high on return; the next call or a gap decides what it does next.
    task automatic send_item(input logic func, input logic [KEY_W-1:0] key);
        if (!no_gaps && $urandom_range(99) < 6) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_func <= func;
        i_key  <= key;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (func == FUNC_INSERT) begin
            inserted_keys.push_back(key);
        end
    endtask

    // Drain: all answers in, block idle, then a full item latency on top, since
    // an insert leaves no result that would tell us it has finished.
    task automatic settle();
        start <= 1'b0;
        @(negedge i_clk);
        while (answers_pending != 0 || busy) @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] size,
                              input logic [CFG_DATA_W-1:0] count);
        cfg_write(CFG_FILTER_SIZE, size);
        cfg_write(CFG_HASH_COUNT, count);
        i_cfg_we <= 1'b0;
    endtask

    // sizes: zero and one, tiny, typical, full, and past the array (saturates)
    function automatic logic [CFG_DATA_W-1:0] pick_size();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'($urandom_range(2, 63));
            3, 4:    return CFG_DATA_W'($urandom_range(64, 1024));
            5, 6:    return CFG_DATA_W'($urandom_range(1025, 65535));
            7:       return CFG_DATA_W'(FILTER_BITS_DEF);
            8:       return CFG_DATA_W'($urandom_range(65537, 131071));
            default: return CFG_DATA_W'(64);
        endcase
    endfunction

    // hash counts lean small to keep items short; zero and saturated ones too.
    // Upper bits of the data word are random junk above the 7-bit register.
    function automatic logic [CFG_DATA_W-1:0] pick_count();
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom) & ~CFG_DATA_W'(8'h7F);
        case ($urandom_range(9))
            0:          return junk;
            1, 2, 3, 4: return junk | CFG_DATA_W'($urandom_range(1, 8));
            5, 6:       return junk | CFG_DATA_W'($urandom_range(9, 32));
            7, 8:       return junk | CFG_DATA_W'($urandom_range(33, 64));
            default:    return junk | CFG_DATA_W'($urandom_range(65, 127));
        endcase
    endfunction

    // Mostly insert-then-query traffic so queries come back positive; the rest
    // queries fresh keys and near misses of stored keys, and sends the zero key.
    task automatic run_traffic(input int count);
        int               pick;
        int               flip;
        logic [KEY_W-1:0] key;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                send_item(FUNC_INSERT, random_key());
            end else if (pick < 75 && inserted_keys.size() != 0) begin
                key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
                if ($urandom_range(9) == 0) begin
                    flip      = $urandom_range(KEY_W - 1);
                    key[flip] = ~key[flip];
                end
                send_item(FUNC_QUERY, key);
            end else if (pick < 78) begin
                send_item($urandom_range(1) ? FUNC_QUERY : FUNC_INSERT, KEY_ZERO);
            end else begin
                send_item(FUNC_QUERY, random_key());
            end
        end
    endtask

    initial begin
        // hold reset, then wait out the clearing pass (busy high)
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        settle();

        // reset settings: full size, 4 hashes; empty array, zero key, key extremes
        send_item(FUNC_QUERY, KEY_ZERO);
        send_item(FUNC_INSERT, KEY_ZERO);
        send_item(FUNC_QUERY, KEY_ZERO);
        send_item(FUNC_QUERY, KEY_ONES);
        send_item(FUNC_INSERT, KEY_ONES);
        send_item(FUNC_QUERY, KEY_ONES);
        send_item(FUNC_INSERT, KEY_MSB);
        send_item(FUNC_QUERY, KEY_MSB);
        send_item(FUNC_QUERY, KEY_LSB);

        // zero size acts as one: every hash lands on bit 0
        settle();
        set_config('0, CFG_DATA_W'(1));
        send_item(FUNC_QUERY, random_key());
        send_item(FUNC_INSERT, KEY_LSB);

        // both registers past their limits: size and count saturate
        settle();
        set_config('1, CFG_DATA_W'(8'h7F));
        send_item(FUNC_INSERT, 64'h0123_4567_89AB_CDEF);
        send_item(FUNC_QUERY, 64'h0123_4567_89AB_CDEF);
        send_item(FUNC_QUERY, KEY_ONES);

        // zero hash count: inserts change nothing, queries always answer 1
        settle();
        set_config(CFG_DATA_W'(1), '0);
        send_item(FUNC_QUERY, random_key());
        send_item(FUNC_INSERT, random_key());

        // undecoded register indexes must leave the settings alone
        settle();
        set_config(CFG_DATA_W'(64), CFG_DATA_W'(MAX_HASHES_DEF));
        cfg_write(CFG_SPARE_IDX, CFG_DATA_W'(5));
        cfg_write(CFG_TOP_IDX, '1);
        i_cfg_we <= 1'b0;
        send_item(FUNC_INSERT, random_key());
        send_item(FUNC_QUERY, KEY_ZERO);
        send_item(FUNC_QUERY, random_key());

        // random phases; phase 3 runs back to back with no idle gaps
        for (int phase = 0; phase < 8; phase++) begin
            settle();
            set_config(pick_size(), pick_count());
            no_gaps = (phase == 3);
            run_traffic(50);
        end
        no_gaps = 1'b0;

        settle();
        if (fault_count == 0 && answers_pending == 0) begin
            $display("bloom_filter_xorshift_chain_tb: done, clean");
        end else begin
            $display("bloom_filter_xorshift_chain_tb: done, errors");
        end
        $finish;
    end

endmodule
